### rtl/jgr_pkg.sv
// Shared constants, codes and controller-to-datapath types for the grid relaxation block.
package jgr_pkg;

  localparam int INTERIOR_SIZE = 32;
  localparam int GRID_DIM      = INTERIOR_SIZE + 2;
  localparam int GRID_CELLS    = GRID_DIM * GRID_DIM;
  localparam int ADDR_W        = $clog2(GRID_CELLS);
  localparam int POS_W         = $clog2(GRID_DIM);
  localparam int DATA_W        = 16;
  localparam int SUM_W         = DATA_W + 2;
  localparam int ROW_W         = 6;
  localparam int OP_W          = 2;
  localparam int CNT_W         = 16;
  localparam int CFG_IDX_W     = 1;
  localparam int CFG_DATA_W    = 16;
  localparam int FIRST_CELL    = GRID_DIM + 1;
  localparam int LAST_CELL     = INTERIOR_SIZE * GRID_DIM + INTERIOR_SIZE;

  localparam logic [DATA_W-1:0] TOL_RESET        = 16'd197;
  localparam logic [CNT_W-1:0]  MAX_SWEEPS_RESET = 16'hFFFF;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_RUN   = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TOLERANCE  = 1'b0,
    REG_MAX_SWEEPS = 1'b1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ADDR_HOST,
    ADDR_UP,
    ADDR_DOWN,
    ADDR_LEFT,
    ADDR_RIGHT,
    ADDR_CENTER
  } addr_sel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CELL,
    ST_SWEEP_END
  } state_t;

  typedef enum logic [2:0] {
    STEP_UP,
    STEP_DOWN,
    STEP_LEFT,
    STEP_RIGHT,
    STEP_CENTER,
    STEP_WRITE
  } cell_step_t;

  typedef struct packed {
    logic      host_write;
    addr_sel_t rd_sel;
    logic      sum_load;
    logic      sum_add;
    logic      cell_write;
    logic      cell_next;
    logic      run_init;
    logic      sweep_end;
    logic      emit_zero;
    logic      emit_read;
    logic      emit_run;
  } dp_cmd_t;

  typedef struct packed {
    logic last_cell;
    logic run_done;
  } dp_stat_t;

endpackage

### rtl/jgr_ctrl.sv
// Controller state machine that sequences items, cell visits and sweeps.
module jgr_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [jgr_pkg::OP_W-1:0]   in_op,
  input  jgr_pkg::dp_stat_t          stat,
  output jgr_pkg::dp_cmd_t           cmd,
  output logic                       busy
);

  jgr_pkg::state_t     state_r, state_nxt;
  jgr_pkg::cell_step_t step_r, step_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= jgr_pkg::ST_IDLE;
      step_r  <= jgr_pkg::STEP_UP;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  assign busy = (state_r != jgr_pkg::ST_IDLE);

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    cmd        = '0;
    cmd.rd_sel = jgr_pkg::ADDR_HOST;
    case (state_r)
      jgr_pkg::ST_IDLE: begin
        if (start) begin
          case (in_op)
            jgr_pkg::OP_WRITE: begin
              cmd.host_write = 1'b1;
              cmd.emit_zero  = 1'b1;
            end
            jgr_pkg::OP_RUN: begin
              cmd.run_init = 1'b1;
              step_nxt     = jgr_pkg::STEP_UP;
              state_nxt    = jgr_pkg::ST_CELL;
            end
            jgr_pkg::OP_READ: begin
              // The host address is on the read port now; data is back next cycle.
              state_nxt = jgr_pkg::ST_READ;
            end
            default: begin
              cmd.emit_zero = 1'b1;
            end
          endcase
        end
      end
      jgr_pkg::ST_READ: begin
        cmd.emit_read = 1'b1;
        state_nxt     = jgr_pkg::ST_IDLE;
      end
      jgr_pkg::ST_CELL: begin
        // UP-CENTER each issue a read; DOWN-WRITE consume the word the prior step read.
        case (step_r)
          jgr_pkg::STEP_UP: begin
            cmd.rd_sel = jgr_pkg::ADDR_UP;
            step_nxt   = jgr_pkg::STEP_DOWN;
          end
          jgr_pkg::STEP_DOWN: begin
            cmd.rd_sel   = jgr_pkg::ADDR_DOWN;
            cmd.sum_load = 1'b1;
            step_nxt     = jgr_pkg::STEP_LEFT;
          end
          jgr_pkg::STEP_LEFT: begin
            cmd.rd_sel  = jgr_pkg::ADDR_LEFT;
            cmd.sum_add = 1'b1;
            step_nxt    = jgr_pkg::STEP_RIGHT;
          end
          jgr_pkg::STEP_RIGHT: begin
            cmd.rd_sel  = jgr_pkg::ADDR_RIGHT;
            cmd.sum_add = 1'b1;
            step_nxt    = jgr_pkg::STEP_CENTER;
          end
          jgr_pkg::STEP_CENTER: begin
            cmd.rd_sel  = jgr_pkg::ADDR_CENTER;
            cmd.sum_add = 1'b1;
            step_nxt    = jgr_pkg::STEP_WRITE;
          end
          jgr_pkg::STEP_WRITE: begin
            cmd.cell_write = 1'b1;
            step_nxt       = jgr_pkg::STEP_UP;
            if (stat.last_cell) begin
              state_nxt = jgr_pkg::ST_SWEEP_END;
            end else begin
              cmd.cell_next = 1'b1;
            end
          end
          default: begin
            step_nxt = jgr_pkg::STEP_UP;
          end
        endcase
      end
      jgr_pkg::ST_SWEEP_END: begin
        cmd.sweep_end = 1'b1;
        if (stat.run_done) begin
          cmd.emit_run = 1'b1;
          state_nxt    = jgr_pkg::ST_IDLE;
        end else begin
          step_nxt  = jgr_pkg::STEP_UP;
          state_nxt = jgr_pkg::ST_CELL;
        end
      end
      default: begin
        state_nxt = jgr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/jgr_datapath.sv
// Datapath: two grid banks, stencil accumulator, convergence test, counters and result registers.
module jgr_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  jgr_pkg::dp_cmd_t                 cmd,
  output jgr_pkg::dp_stat_t                stat,
  input  logic [jgr_pkg::ROW_W-1:0]        in_row,
  input  logic [jgr_pkg::ROW_W-1:0]        in_col,
  input  logic [jgr_pkg::DATA_W-1:0]       in_value,
  input  logic                             cfg_we,
  input  logic [jgr_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [jgr_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output logic                             out_valid,
  output logic [jgr_pkg::DATA_W-1:0]       out_read_value,
  output logic [jgr_pkg::CNT_W-1:0]        out_sweeps_done,
  output logic                             out_converged
);

  localparam int AW = jgr_pkg::ADDR_W;
  localparam int DW = jgr_pkg::DATA_W;

  // Two banks; sel_r names the bank holding the current grid. Border cells are
  // written to both banks by the host and never by a sweep, so they match.
  logic [DW-1:0] mem0 [jgr_pkg::GRID_CELLS];
  logic [DW-1:0] mem1 [jgr_pkg::GRID_CELLS];
  logic [DW-1:0] q0_r, q1_r;
  logic          sel_r;

  logic [DW-1:0]              tol_r;
  logic [jgr_pkg::CNT_W-1:0]  max_r;
  logic [AW-1:0]              pos_r;
  logic [jgr_pkg::POS_W-1:0]  col_r;
  logic [jgr_pkg::SUM_W-1:0]  sum_r;
  logic [jgr_pkg::CNT_W-1:0]  sweeps_r;
  logic                       settled_r;
  logic                       rd_inside_r;

  logic                       out_valid_r;
  logic [DW-1:0]              out_read_value_r;
  logic [jgr_pkg::CNT_W-1:0]  out_sweeps_done_r;
  logic                       out_converged_r;

  logic                       host_inside;
  logic [AW-1:0]              host_addr;
  logic [AW-1:0]              rd_addr;
  logic [AW-1:0]              wr_addr;
  logic [DW-1:0]              wr_data;
  logic                       we0, we1;
  logic [DW-1:0]              rdata;
  logic [DW-1:0]              new_val;
  logic [DW-1:0]              diff;
  logic [jgr_pkg::CNT_W-1:0]  cap;
  logic [jgr_pkg::CNT_W:0]    sweeps_inc;

  assign host_inside = (32'(in_row) < jgr_pkg::GRID_DIM) && (32'(in_col) < jgr_pkg::GRID_DIM);
  assign host_addr   = AW'(32'(in_row) * jgr_pkg::GRID_DIM + 32'(in_col));

  always_comb begin
    case (cmd.rd_sel)
      jgr_pkg::ADDR_HOST:   rd_addr = host_addr;
      jgr_pkg::ADDR_UP:     rd_addr = pos_r - AW'(jgr_pkg::GRID_DIM);
      jgr_pkg::ADDR_DOWN:   rd_addr = pos_r + AW'(jgr_pkg::GRID_DIM);
      jgr_pkg::ADDR_LEFT:   rd_addr = pos_r - AW'(1);
      jgr_pkg::ADDR_RIGHT:  rd_addr = pos_r + AW'(1);
      jgr_pkg::ADDR_CENTER: rd_addr = pos_r;
      default:              rd_addr = host_addr;
    endcase
  end

  assign rdata   = sel_r ? q1_r : q0_r;
  assign new_val = sum_r[jgr_pkg::SUM_W-1:2];
  assign diff    = (new_val > rdata) ? (new_val - rdata) : (rdata - new_val);

  assign wr_addr = cmd.cell_write ? pos_r : host_addr;
  assign wr_data = cmd.cell_write ? new_val : in_value;
  assign we0     = (cmd.host_write && host_inside) || (cmd.cell_write && sel_r);
  assign we1     = (cmd.host_write && host_inside) || (cmd.cell_write && !sel_r);

  always_ff @(posedge clk) begin
    if (we0) begin
      mem0[wr_addr] <= wr_data;
    end
    q0_r <= mem0[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (we1) begin
      mem1[wr_addr] <= wr_data;
    end
    q1_r <= mem1[rd_addr];
  end

  // A sweep cap of zero behaves as a cap of one.
  assign cap        = (max_r == '0) ? jgr_pkg::CNT_W'(1) : max_r;
  assign sweeps_inc = {1'b0, sweeps_r} + (jgr_pkg::CNT_W + 1)'(1);

  assign stat.last_cell = (pos_r == AW'(jgr_pkg::LAST_CELL));
  assign stat.run_done  = settled_r || (sweeps_inc >= {1'b0, cap});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= jgr_pkg::TOL_RESET;
      max_r <= jgr_pkg::MAX_SWEEPS_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        jgr_pkg::REG_TOLERANCE:  tol_r <= cfg_wdata;
        jgr_pkg::REG_MAX_SWEEPS: max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r     <= 1'b0;
      pos_r     <= AW'(jgr_pkg::FIRST_CELL);
      col_r     <= jgr_pkg::POS_W'(1);
      sweeps_r  <= '0;
      settled_r <= 1'b1;
    end else begin
      if (cmd.run_init) begin
        pos_r     <= AW'(jgr_pkg::FIRST_CELL);
        col_r     <= jgr_pkg::POS_W'(1);
        sweeps_r  <= '0;
        settled_r <= 1'b1;
      end else if (cmd.sweep_end) begin
        sel_r     <= ~sel_r;
        pos_r     <= AW'(jgr_pkg::FIRST_CELL);
        col_r     <= jgr_pkg::POS_W'(1);
        sweeps_r  <= sweeps_inc[jgr_pkg::CNT_W-1:0];
        settled_r <= 1'b1;
      end else begin
        if (cmd.cell_write && (diff >= tol_r)) begin
          settled_r <= 1'b0;
        end
        if (cmd.cell_next) begin
          // At the end of a row, skip the right border and the next row's left border.
          if (col_r == jgr_pkg::POS_W'(jgr_pkg::INTERIOR_SIZE)) begin
            pos_r <= pos_r + AW'(3);
            col_r <= jgr_pkg::POS_W'(1);
          end else begin
            pos_r <= pos_r + AW'(1);
            col_r <= col_r + jgr_pkg::POS_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_load) begin
      sum_r <= jgr_pkg::SUM_W'(rdata);
    end else if (cmd.sum_add) begin
      sum_r <= sum_r + jgr_pkg::SUM_W'(rdata);
    end
    if (cmd.rd_sel == jgr_pkg::ADDR_HOST) begin
      rd_inside_r <= host_inside;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_zero || cmd.emit_read || cmd.emit_run;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_zero) begin
      out_read_value_r  <= '0;
      out_sweeps_done_r <= '0;
      out_converged_r   <= 1'b0;
    end else if (cmd.emit_read) begin
      out_read_value_r  <= rd_inside_r ? rdata : '0;
      out_sweeps_done_r <= '0;
      out_converged_r   <= 1'b0;
    end else if (cmd.emit_run) begin
      out_read_value_r  <= '0;
      out_sweeps_done_r <= sweeps_inc[jgr_pkg::CNT_W-1:0];
      out_converged_r   <= settled_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_read_value_r;
  assign out_sweeps_done = out_sweeps_done_r;
  assign out_converged   = out_converged_r;

endmodule

### rtl/jacobi_grid_relaxation.sv
// Top level of the Jacobi relaxation block: controller plus datapath.
// An item is taken when start is high and busy is low; its single result appears on the
// out_ ports for one cycle with out_valid high and cannot be held off. A write item, or an
// item with the unused op code, gives its result in the next cycle and busy stays low, so
// such items can follow each other every cycle. A read item keeps busy high for one cycle
// and its result passes the bank's read register, then the output register. A run item
// takes each interior cell through UP, DOWN, LEFT, RIGHT, CENTER and WRITE: its four
// neighbors and its old value are fetched one word per cycle through the single read port
// of the grid bank, and each sweep ends with a state that swaps the two banks and checks
// for convergence. The grid memory is not cleared after reset; every cell must be written
// before a run or a read uses it. Configuration must be written while idle (not enforced).
module jacobi_grid_relaxation (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [jgr_pkg::OP_W-1:0]         in_op,
  input  logic [jgr_pkg::ROW_W-1:0]        in_row,
  input  logic [jgr_pkg::ROW_W-1:0]        in_col,
  input  logic [jgr_pkg::DATA_W-1:0]       in_value,
  output logic                             out_valid,
  output logic [jgr_pkg::DATA_W-1:0]       out_read_value,
  output logic [jgr_pkg::CNT_W-1:0]        out_sweeps_done,
  output logic                             out_converged,
  input  logic                             cfg_we,
  input  logic [jgr_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [jgr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  jgr_pkg::dp_cmd_t  cmd;
  jgr_pkg::dp_stat_t stat;

  jgr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  jgr_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_row          (in_row),
    .in_col          (in_col),
    .in_value        (in_value),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_read_value  (out_read_value),
    .out_sweeps_done (out_sweeps_done),
    .out_converged   (out_converged)
  );

endmodule

### rtl/jgr_checker.sv
// Port-level checker for the relaxation block and its bind to the top level.
module jgr_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           start,
  input logic                           busy,
  input logic [jgr_pkg::OP_W-1:0]       in_op,
  input logic                           out_valid,
  input logic [jgr_pkg::DATA_W-1:0]     out_read_value,
  input logic [jgr_pkg::CNT_W-1:0]      out_sweeps_done,
  input logic                           out_converged
);

  // A write item answers in the next cycle with an all-zero result.
  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_op == jgr_pkg::OP_WRITE)) |=>
      (out_valid && (out_read_value == '0) && (out_sweeps_done == '0) && !out_converged))
    else $error("write item did not give a zero result in the next cycle");

  // Read and run items hold the block busy and give no result in the next cycle.
  a_long_item_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && ((in_op == jgr_pkg::OP_READ) || (in_op == jgr_pkg::OP_RUN))) |=>
      (busy && !out_valid))
    else $error("read or run item did not hold busy");

  // A result is only shown once the block is free for the next item.
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // A converged run has done at least one sweep.
  a_conv_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_converged) |-> (out_sweeps_done != '0))
    else $error("converged result with zero sweeps");

endmodule

bind jacobi_grid_relaxation jgr_checker u_jgr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_op           (in_op),
  .out_valid       (out_valid),
  .out_read_value  (out_read_value),
  .out_sweeps_done (out_sweeps_done),
  .out_converged   (out_converged)
);

### tb/sv/tb_top.sv
// Self-checking testbench for the grid relaxation block, with an in-bench sweep predictor.
module tb_top;

  localparam logic [jgr_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SEGMENTS      = 6;
  localparam int SEGMENT_ITEMS = 150;
  localparam int TAIL_CYCLES   = 20;

  typedef struct {
    logic [jgr_pkg::OP_W-1:0]   op;
    logic [jgr_pkg::ROW_W-1:0]  row;
    logic [jgr_pkg::ROW_W-1:0]  col;
    logic [jgr_pkg::DATA_W-1:0] value;
  } cell_item_t;

  typedef struct {
    logic [jgr_pkg::DATA_W-1:0] read_value;
    logic [jgr_pkg::CNT_W-1:0]  sweeps_done;
    logic                       converged;
  } cell_result_t;

  logic                           clk       = 1'b0;
  logic                           rst_n     = 1'b0;
  logic                           start     = 1'b0;
  logic                           busy;
  logic [jgr_pkg::OP_W-1:0]       in_op     = '0;
  logic [jgr_pkg::ROW_W-1:0]      in_row    = '0;
  logic [jgr_pkg::ROW_W-1:0]      in_col    = '0;
  logic [jgr_pkg::DATA_W-1:0]     in_value  = '0;
  logic                           out_valid;
  logic [jgr_pkg::DATA_W-1:0]     out_read_value;
  logic [jgr_pkg::CNT_W-1:0]      out_sweeps_done;
  logic                           out_converged;
  logic                           cfg_we    = 1'b0;
  logic [jgr_pkg::CFG_IDX_W-1:0]  cfg_addr  = '0;
  logic [jgr_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  cell_item_t   pending_items[$];
  cell_result_t expected_results[$];
  cell_item_t   in_flight;
  cell_result_t oldest;

  // Predictor copy of the grid and of the two registers.
  logic [jgr_pkg::DATA_W-1:0] grid_now [jgr_pkg::GRID_CELLS];
  logic [jgr_pkg::DATA_W-1:0] grid_new [jgr_pkg::GRID_CELLS];
  logic [jgr_pkg::DATA_W-1:0] tol_now   = jgr_pkg::TOL_RESET;
  logic [jgr_pkg::CNT_W-1:0]  sweep_cap = jgr_pkg::MAX_SWEEPS_RESET;

  int fail_count = 0;
  int idle_left  = 0;
  int runs_left  = 24;
  bit quiet_tail = 1'b0;

  jacobi_grid_relaxation uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_row         (in_row),
    .in_col         (in_col),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_read_value (out_read_value),
    .out_sweeps_done(out_sweeps_done),
    .out_converged  (out_converged),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata)
  );

  always #6 clk = ~clk;

  // One full sweep over the interior; returns 1 when every cell moved by less than tol_now.
  function automatic bit sweep_grid();
    bit          settled;
    int          r;
    int          c;
    int          p;
    int unsigned sum;
    int unsigned nv;
    int unsigned ov;
    int unsigned diff;
    settled = 1'b1;
    for (r = 1; r <= jgr_pkg::INTERIOR_SIZE; r++) begin
      for (c = 1; c <= jgr_pkg::INTERIOR_SIZE; c++) begin
        p = r * jgr_pkg::GRID_DIM + c;
        sum = 32'(grid_now[p - jgr_pkg::GRID_DIM]) + 32'(grid_now[p + jgr_pkg::GRID_DIM])
            + 32'(grid_now[p - 1]) + 32'(grid_now[p + 1]);
        nv = sum >> 2;
        ov = 32'(grid_now[p]);
        diff = (nv > ov) ? nv - ov : ov - nv;
        grid_new[p] = nv[jgr_pkg::DATA_W-1:0];
        if (diff >= 32'(tol_now)) settled = 1'b0;
      end
    end
    for (r = 1; r <= jgr_pkg::INTERIOR_SIZE; r++) begin
      for (c = 1; c <= jgr_pkg::INTERIOR_SIZE; c++) begin
        grid_now[r * jgr_pkg::GRID_DIM + c] = grid_new[r * jgr_pkg::GRID_DIM + c];
      end
    end
    return settled;
  endfunction

  function automatic cell_result_t predict_item(cell_item_t it);
    cell_result_t res;
    bit           on_grid;
    int           idx;
    int unsigned  cap;
    int unsigned  done;
    bit           conv;
    res = '{default: '0};
    on_grid = (it.row < jgr_pkg::GRID_DIM) && (it.col < jgr_pkg::GRID_DIM);
    idx = on_grid ? int'(it.row) * jgr_pkg::GRID_DIM + int'(it.col) : 0;
    case (it.op)
      jgr_pkg::OP_WRITE: begin
        if (on_grid) grid_now[idx] = it.value;
      end
      jgr_pkg::OP_RUN: begin
        // A cap of zero behaves as a cap of one.
        cap = (sweep_cap == '0) ? 1 : 32'(sweep_cap);
        done = 0;
        conv = 1'b0;
        while (done < cap && !conv) begin
          conv = sweep_grid();
          done++;
        end
        res.sweeps_done = done[jgr_pkg::CNT_W-1:0];
        res.converged = conv;
      end
      jgr_pkg::OP_READ: begin
        if (on_grid) res.read_value = grid_now[idx];
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  // Driver: an item is predicted at the edge where it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (start) expected_results.push_back(predict_item(in_flight));
      if (idle_left > 0) begin
        idle_left--;
        start <= 1'b0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        idle_left = $urandom_range(1, 12) - 1;
        start <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_flight = pending_items.pop_front();
        start    <= 1'b1;
        in_op    <= in_flight.op;
        in_row   <= in_flight.row;
        in_col   <= in_flight.col;
        in_value <= in_flight.value;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result is matched against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: read_value %0h sweeps_done %0d converged %0b",
               out_read_value, out_sweeps_done, out_converged);
        fail_count++;
      end else begin
        oldest = expected_results.pop_front();
        if (out_read_value !== oldest.read_value) begin
          $error("read_value: expected %0h, actual %0h", oldest.read_value, out_read_value);
          fail_count++;
        end
        if (out_sweeps_done !== oldest.sweeps_done) begin
          $error("sweeps_done: expected %0d, actual %0d", oldest.sweeps_done, out_sweeps_done);
          fail_count++;
        end
        if (out_converged !== oldest.converged) begin
          $error("converged: expected %0b, actual %0b", oldest.converged, out_converged);
          fail_count++;
        end
      end
    end
  end

  function automatic logic [jgr_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return jgr_pkg::DATA_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic push_item(logic [jgr_pkg::OP_W-1:0] op, int row, int col,
                           logic [jgr_pkg::DATA_W-1:0] value);
    cell_item_t it;
    it.op = op;
    it.row = jgr_pkg::ROW_W'(row);
    it.col = jgr_pkg::ROW_W'(col);
    it.value = value;
    pending_items.push_back(it);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || start || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(jgr_pkg::cfg_reg_t idx, logic [jgr_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == jgr_pkg::REG_TOLERANCE) tol_now = data;
    else sweep_cap = data;
  endtask

  task automatic set_config(logic [jgr_pkg::DATA_W-1:0] tol, logic [jgr_pkg::CNT_W-1:0] cap);
    wait_drained();
    write_reg(jgr_pkg::REG_TOLERANCE, tol);
    write_reg(jgr_pkg::REG_MAX_SWEEPS, cap);
  endtask

  // Writes every cell, border included; uniform grids converge in one sweep unless the tolerance is zero.
  task automatic fill_grid(bit uniform, logic [jgr_pkg::DATA_W-1:0] level);
    int r;
    int c;
    for (r = 0; r < jgr_pkg::GRID_DIM; r++) begin
      for (c = 0; c < jgr_pkg::GRID_DIM; c++) begin
        push_item(jgr_pkg::OP_WRITE, r, c, uniform ? level : pick_value());
      end
    end
  endtask

  task automatic push_run();
    push_item(jgr_pkg::OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63), pick_value());
  endtask

  task automatic push_off_grid(logic [jgr_pkg::OP_W-1:0] op);
    if ($urandom_range(0, 1))
      push_item(op, $urandom_range(jgr_pkg::GRID_DIM, 63), $urandom_range(0, 63),
                pick_value());
    else
      push_item(op, $urandom_range(0, 63), $urandom_range(jgr_pkg::GRID_DIM, 63),
                pick_value());
  endtask

  task automatic push_random_segment(int count);
    int n;
    int r;
    int c;
    int roll;
    for (n = 0; n < count; n++) begin
      r = $urandom_range(0, jgr_pkg::GRID_DIM - 1);
      c = $urandom_range(0, jgr_pkg::GRID_DIM - 1);
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        push_item(jgr_pkg::OP_WRITE, r, c, pick_value());
      end else if (roll < 40) begin
        push_off_grid(jgr_pkg::OP_WRITE);
      end else if (roll < 50) begin
        push_item(jgr_pkg::OP_WRITE, r, c, pick_value());
        push_item(jgr_pkg::OP_READ, r, c, pick_value());
      end else if (roll < 85) begin
        push_item(jgr_pkg::OP_READ, r, c, pick_value());
      end else if (roll < 90) begin
        push_off_grid(jgr_pkg::OP_READ);
      end else if (roll < 97) begin
        push_item(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63), pick_value());
      end else if (runs_left > 0) begin
        runs_left--;
        push_run();
      end else begin
        push_item(jgr_pkg::OP_READ, r, c, pick_value());
      end
    end
  endtask

  function automatic logic [jgr_pkg::DATA_W-1:0] pick_tolerance();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return jgr_pkg::TOL_RESET;
      3:       return jgr_pkg::DATA_W'($urandom_range(1, 64));
      default: return jgr_pkg::DATA_W'($urandom_range(1000, 65535));
    endcase
  endfunction

  initial begin
    int seg;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Corners and border extremes, read back before any run.
    push_item(jgr_pkg::OP_WRITE, 0, 0, 16'h0000);
    push_item(jgr_pkg::OP_WRITE, jgr_pkg::GRID_DIM - 1, jgr_pkg::GRID_DIM - 1, 16'hFFFF);
    push_item(jgr_pkg::OP_WRITE, 0, jgr_pkg::GRID_DIM - 1, 16'hAAAA);
    push_item(jgr_pkg::OP_WRITE, jgr_pkg::GRID_DIM - 1, 0, 16'h5555);
    push_item(jgr_pkg::OP_READ, 0, 0, 16'hFFFF);
    push_item(jgr_pkg::OP_READ, jgr_pkg::GRID_DIM - 1, jgr_pkg::GRID_DIM - 1, 16'h0000);
    push_item(jgr_pkg::OP_READ, 0, jgr_pkg::GRID_DIM - 1, 16'h0000);
    push_item(jgr_pkg::OP_READ, jgr_pkg::GRID_DIM - 1, 0, 16'h0000);
    // Cells outside the grid: writes are dropped and reads answer zero.
    push_item(jgr_pkg::OP_WRITE, 63, 63, 16'h1234);
    push_item(jgr_pkg::OP_WRITE, jgr_pkg::GRID_DIM, 0, 16'hFFFF);
    push_item(jgr_pkg::OP_READ, 63, 0, 16'h0000);
    push_item(jgr_pkg::OP_READ, 0, jgr_pkg::GRID_DIM, 16'h0000);
    push_item(OP_UNUSED, 63, 63, 16'hFFFF);
    push_item(OP_UNUSED, 0, 0, 16'h0000);

    // A flat grid settles in one sweep even with the largest cap.
    fill_grid(1'b1, 16'h8000);
    set_config(16'd1, 16'hFFFF);
    push_item(jgr_pkg::OP_RUN, 63, 63, 16'hFFFF);
    push_item(jgr_pkg::OP_READ, jgr_pkg::INTERIOR_SIZE / 2, jgr_pkg::INTERIOR_SIZE / 2,
              16'h0000);
    push_item(jgr_pkg::OP_READ, 0, 0, 16'h0000);

    // Zero tolerance never settles, and a zero cap still does one sweep.
    set_config(16'd0, 16'd0);
    push_item(jgr_pkg::OP_RUN, 0, 0, 16'h0000);
    push_item(jgr_pkg::OP_READ, 1, 1, 16'h0000);

    fill_grid(1'b0, 16'h0000);
    set_config(16'hFFFF, 16'd2);
    push_run();
    push_item(jgr_pkg::OP_READ, 1, jgr_pkg::INTERIOR_SIZE, 16'h0000);
    push_item(jgr_pkg::OP_READ, jgr_pkg::INTERIOR_SIZE, 1, 16'h0000);
    set_config(16'd0, 16'd3);
    push_run();
    push_item(jgr_pkg::OP_READ, jgr_pkg::INTERIOR_SIZE, jgr_pkg::INTERIOR_SIZE, 16'h0000);

    for (seg = 0; seg < SEGMENTS; seg++) begin
      set_config(pick_tolerance(), jgr_pkg::CNT_W'($urandom_range(0, 4)));
      if (seg == SEGMENTS - 1) quiet_tail = 1'b1;
      push_random_segment(SEGMENT_ITEMS);
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
